/* rtl/core/millisecond_count_to_civil_date_unit_assert.svh */
// Assertion macros for the civil date unit checks
`ifndef MILLISECOND_COUNT_TO_CIVIL_DATE_UNIT_ASSERT_SVH
`define MILLISECOND_COUNT_TO_CIVIL_DATE_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define MCD_ASSERT_IMP(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("civil date unit check failed");

// Next-cycle implication, off during reset
`define MCD_ASSERT_NXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("civil date unit check failed");

// Next-cycle implication, live during reset
`define MCD_ASSERT_ALWAYS_NXT(lbl, ck, pre, post) \
  lbl: assert property (@(posedge ck) (pre) |=> (post)) \
    else $error("civil date unit reset check failed");

`endif

/* rtl/core/mcd_pkg.sv */
// Constants, stage types and helper functions of the civil date unit
package mcd_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int unsigned MS_W    = 49;
  localparam int unsigned DAYS_W  = 23;
  localparam int unsigned TOD_W   = 27;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned YACC_W  = 15;
  localparam int unsigned DIV_W   = 24;

  localparam int unsigned DAY_MS  = 86400000;
  localparam int unsigned HOUR_MS = 3600000;
  localparam int unsigned MIN_MS  = 60000;
  localparam int unsigned SEC_MS  = 1000;

  localparam int unsigned CYCLE_DAYS = 146097;
  localparam int unsigned CENT_DAYS  = 36524;
  localparam int unsigned QUAD_DAYS  = 1461;
  localparam int unsigned YEAR_DAYS  = 365;

  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned CENT_YEARS  = 100;
  localparam int unsigned QUAD_YEARS  = 4;
  localparam int unsigned LAST_CENT   = 3;
  localparam int unsigned LAST_QUAD   = 24;
  localparam int unsigned LAST_YEAR   = 3;

  localparam int unsigned DIV_STAGES = 6;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned PIPE_STAGES = 12;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [TOD_W-1:0] rem;
    logic [DIV_W-1:0] word;
  } day_div_t;

  typedef struct packed {
    logic        oor;
    logic [2:0]  wd;
    logic [5:0]  cycles;
    logic [17:0] rem_c;
    logic [4:0]  hour;
    logic [21:0] rem_h;
  } e1_t;

  typedef struct packed {
    logic              oor;
    logic [2:0]        wd;
    logic [1:0]        c100;
    logic [15:0]       rem2;
    logic [YACC_W-1:0] yb;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [15:0]       rem_m;
  } e2_t;

  typedef struct packed {
    logic              oor;
    logic [2:0]        wd;
    logic [1:0]        c100;
    logic [4:0]        c4;
    logic [10:0]       rem3;
    logic [YACC_W-1:0] yb;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        milli;
  } e3_t;

  typedef struct packed {
    logic              oor;
    logic [2:0]        wd;
    logic [YACC_W-1:0] yr;
    logic              leap;
    logic [8:0]        rem4;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        milli;
  } e4_t;

  typedef struct packed {
    logic              oor;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        milli;
    logic [2:0]        wd;
  } e5_t;

  // Four restoring steps of the day-count long division
  function automatic day_div_t day_div_steps(day_div_t s);
    day_div_t         o;
    logic [TOD_W:0]   t;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {o.rem, o.word[DIV_W-1]};
      o.word = {o.word[DIV_W-2:0], 1'b0};
      if (t >= (TOD_W+1)'(DAY_MS)) begin
        t = t - (TOD_W+1)'(DAY_MS);
        o.word[0] = 1'b1;
      end
      o.rem = t[TOD_W-1:0];
    end
    return o;
  endfunction

  // Day count modulo 7: octal digits fold since 8 is 1 mod 7
  function automatic logic [2:0] mod7(logic [DAYS_W-1:0] d);
    logic [23:0] p;
    logic [5:0]  s;
    logic [3:0]  f;
    logic [3:0]  g;
    p = 24'(d);
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(p[3*i +: 3]);
    end
    f = 4'(s[5:3]) + 4'(s[2:0]);
    g = 4'(f[3]) + 4'(f[2:0]);
    return (g >= 4'd7) ? 3'(g - 4'd7) : g[2:0];
  endfunction

  // Day of year on which a month starts, month index from 0
  function automatic logic [8:0] month_start(logic [3:0] idx, logic leap);
    return MONTH_START[idx] + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

/* rtl/core/mcd_day_div.sv */
// Six-stage long division of the millisecond count into days and time of day
module mcd_day_div (
  input  logic                          clk,
  input  logic [mcd_pkg::DIV_STAGES-1:0] en,
  input  logic [mcd_pkg::MS_W-1:0]      ms,
  output logic [mcd_pkg::DAYS_W-1:0]    days,
  output logic [mcd_pkg::TOD_W-1:0]     tod
);

  mcd_pkg::day_div_t st   [mcd_pkg::DIV_STAGES];
  mcd_pkg::day_div_t st_next [mcd_pkg::DIV_STAGES];
  mcd_pkg::day_div_t init;

  // top bits of the count already lie below one day, so they seed the remainder
  always_comb begin
    init.rem  = mcd_pkg::TOD_W'(ms[mcd_pkg::MS_W-1:mcd_pkg::DIV_W]);
    init.word = ms[mcd_pkg::DIV_W-1:0];
    st_next[0] = mcd_pkg::day_div_steps(init);
    for (int k = 1; k < mcd_pkg::DIV_STAGES; k++) begin
      st_next[k] = mcd_pkg::day_div_steps(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mcd_pkg::DIV_STAGES; k++) begin
      if (en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign days = st[mcd_pkg::DIV_STAGES-1].word[mcd_pkg::DAYS_W-1:0];
  assign tod  = st[mcd_pkg::DIV_STAGES-1].rem;

endmodule

/* rtl/core/millisecond_count_to_civil_date_unit.sv */
// Pipelined converter from a millisecond count to a proleptic Gregorian date and time
// One word enters per cycle while nothing stalls, and passes through these stages:
// one input stage, six stages of a restoring long division by the day length (four
// quotient bits each, 24 in all), and five calendar stages that peel off 400-year
// cycles, centuries, four-year groups, years and months while the time of day is
// split into hours, minutes, seconds and milliseconds alongside. Each stage holds
// its word only while the stage after it is full and stalled, so bubbles close up
// and the input stays ready while a finished result waits on the output as long as
// some stage is still empty; once all 12 stages are full, in_ready follows out_ready.
// Counts at or past the first millisecond of year MAX_YEAR+1 come out with
// out_of_range set and every other field zero.
module millisecond_count_to_civil_date_unit #(
  parameter int unsigned MAX_YEAR = mcd_pkg::MAX_YEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mcd_pkg::MS_W-1:0]       ms_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mcd_pkg::YEAR_W-1:0]     year_num,
  output logic [3:0]                     month_num,
  output logic [4:0]                     day_num,
  output logic [4:0]                     hour_num,
  output logic [5:0]                     minute_num,
  output logic [5:0]                     second_num,
  output logic [9:0]                     milli_num,
  output logic [2:0]                     weekday,
  output logic                           out_of_range
);

  localparam longint unsigned LimitDays = longint'(MAX_YEAR) * 365 + MAX_YEAR / 4
                                          - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam longint unsigned LimitMs   = LimitDays * longint'(mcd_pkg::DAY_MS);

  logic [mcd_pkg::PIPE_STAGES-1:0] v;
  logic [mcd_pkg::PIPE_STAGES:0]   en;

  logic [mcd_pkg::MS_W-1:0]       ms_r;
  logic [mcd_pkg::DIV_STAGES:0]   oor_p;
  logic [mcd_pkg::DAYS_W-1:0]     days_d;
  logic [mcd_pkg::TOD_W-1:0]      tod_d;

  mcd_pkg::e1_t e1, e1_next;
  mcd_pkg::e2_t e2, e2_next;
  mcd_pkg::e3_t e3, e3_next;
  mcd_pkg::e4_t e4, e4_next;
  mcd_pkg::e5_t e5, e5_next;

  // a stage may load when empty or when the stage after it moves
  always_comb begin
    en[mcd_pkg::PIPE_STAGES] = out_ready;
    for (int i = mcd_pkg::PIPE_STAGES - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < mcd_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ms_r     <= ms_count;
      oor_p[0] <= (64'(ms_count) >= LimitMs);
    end
    for (int i = 1; i <= mcd_pkg::DIV_STAGES; i++) begin
      if (en[i]) begin
        oor_p[i] <= oor_p[i-1];
      end
    end
  end

  mcd_day_div u_div (
    .clk  (clk),
    .en   (en[mcd_pkg::DIV_STAGES:1]),
    .ms   (ms_r),
    .days (days_d),
    .tod  (tod_d)
  );

  // 400-year cycles, weekday, hours
  always_comb begin : p_e1
    logic [17:0] r_c;
    logic [18:0] t_c;
    logic [21:0] r_h;
    logic [22:0] t_h;
    r_c = {1'b0, days_d[22:6]};
    r_h = tod_d[26:5];
    e1_next.oor = oor_p[mcd_pkg::DIV_STAGES];
    e1_next.wd  = mcd_pkg::mod7(days_d);
    for (int i = 5; i >= 0; i--) begin
      t_c = {r_c, days_d[i]};
      e1_next.cycles[i] = (t_c >= 19'(mcd_pkg::CYCLE_DAYS));
      if (e1_next.cycles[i]) begin
        t_c = t_c - 19'(mcd_pkg::CYCLE_DAYS);
      end
      r_c = t_c[17:0];
    end
    for (int i = 4; i >= 0; i--) begin
      t_h = {r_h, tod_d[i]};
      e1_next.hour[i] = (t_h >= 23'(mcd_pkg::HOUR_MS));
      if (e1_next.hour[i]) begin
        t_h = t_h - 23'(mcd_pkg::HOUR_MS);
      end
      r_h = t_h[21:0];
    end
    e1_next.rem_c = r_c;
    e1_next.rem_h = r_h;
  end

  // centuries, base year, minutes
  always_comb begin : p_e2
    logic [17:0] diff;
    logic [15:0] r_m;
    logic [16:0] t_m;
    e2_next.oor  = e1.oor;
    e2_next.wd   = e1.wd;
    e2_next.hour = e1.hour;
    if (e1.rem_c >= 18'(3 * mcd_pkg::CENT_DAYS)) begin
      e2_next.c100 = 2'd3;
    end else if (e1.rem_c >= 18'(2 * mcd_pkg::CENT_DAYS)) begin
      e2_next.c100 = 2'd2;
    end else if (e1.rem_c >= 18'(mcd_pkg::CENT_DAYS)) begin
      e2_next.c100 = 2'd1;
    end else begin
      e2_next.c100 = 2'd0;
    end
    diff = e1.rem_c - 18'(e2_next.c100) * 18'(mcd_pkg::CENT_DAYS);
    e2_next.rem2 = diff[15:0];
    e2_next.yb = mcd_pkg::YACC_W'(e1.cycles) * mcd_pkg::YACC_W'(mcd_pkg::CYCLE_YEARS)
                 + mcd_pkg::YACC_W'(e2_next.c100) * mcd_pkg::YACC_W'(mcd_pkg::CENT_YEARS)
                 + mcd_pkg::YACC_W'(1);
    r_m = e1.rem_h[21:6];
    for (int i = 5; i >= 0; i--) begin
      t_m = {r_m, e1.rem_h[i]};
      e2_next.minute[i] = (t_m >= 17'(mcd_pkg::MIN_MS));
      if (e2_next.minute[i]) begin
        t_m = t_m - 17'(mcd_pkg::MIN_MS);
      end
      r_m = t_m[15:0];
    end
    e2_next.rem_m = r_m;
  end

  // four-year groups, seconds and milliseconds
  always_comb begin : p_e3
    logic [10:0] r_q;
    logic [11:0] t_q;
    logic [9:0]  r_s;
    logic [10:0] t_s;
    e3_next.oor    = e2.oor;
    e3_next.wd     = e2.wd;
    e3_next.c100   = e2.c100;
    e3_next.yb     = e2.yb;
    e3_next.hour   = e2.hour;
    e3_next.minute = e2.minute;
    r_q = e2.rem2[15:5];
    for (int i = 4; i >= 0; i--) begin
      t_q = {r_q, e2.rem2[i]};
      e3_next.c4[i] = (t_q >= 12'(mcd_pkg::QUAD_DAYS));
      if (e3_next.c4[i]) begin
        t_q = t_q - 12'(mcd_pkg::QUAD_DAYS);
      end
      r_q = t_q[10:0];
    end
    e3_next.rem3 = r_q;
    r_s = e2.rem_m[15:6];
    for (int i = 5; i >= 0; i--) begin
      t_s = {r_s, e2.rem_m[i]};
      e3_next.second[i] = (t_s >= 11'(mcd_pkg::SEC_MS));
      if (e3_next.second[i]) begin
        t_s = t_s - 11'(mcd_pkg::SEC_MS);
      end
      r_s = t_s[9:0];
    end
    e3_next.milli = r_s;
  end

  // year within the group, leap flag, full year
  always_comb begin : p_e4
    logic [1:0]  y1;
    logic [10:0] diff;
    e4_next.oor    = e3.oor;
    e4_next.wd     = e3.wd;
    e4_next.hour   = e3.hour;
    e4_next.minute = e3.minute;
    e4_next.second = e3.second;
    e4_next.milli  = e3.milli;
    if (e3.rem3 >= 11'(3 * mcd_pkg::YEAR_DAYS)) begin
      y1 = 2'd3;
    end else if (e3.rem3 >= 11'(2 * mcd_pkg::YEAR_DAYS)) begin
      y1 = 2'd2;
    end else if (e3.rem3 >= 11'(mcd_pkg::YEAR_DAYS)) begin
      y1 = 2'd1;
    end else begin
      y1 = 2'd0;
    end
    diff = e3.rem3 - 11'(y1) * 11'(mcd_pkg::YEAR_DAYS);
    e4_next.rem4 = diff[8:0];
    // last year of a group is leap, but not at a century end unless the cycle ends too
    e4_next.leap = (y1 == 2'(mcd_pkg::LAST_YEAR)) &&
                   ((e3.c4 != 5'(mcd_pkg::LAST_QUAD)) ||
                    (e3.c100 == 2'(mcd_pkg::LAST_CENT)));
    e4_next.yr = e3.yb + mcd_pkg::YACC_W'(e3.c4) * mcd_pkg::YACC_W'(mcd_pkg::QUAD_YEARS)
                 + mcd_pkg::YACC_W'(y1);
  end

  // month and day, then clear every field but the flag for counts out of range
  always_comb begin : p_e5
    logic [3:0] mi;
    logic [8:0] dd;
    mi = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (e4.rem4 >= mcd_pkg::month_start(4'(i), e4.leap)) begin
        mi = 4'(i);
      end
    end
    dd = e4.rem4 - mcd_pkg::month_start(mi, e4.leap) + 9'd1;
    e5_next.oor = e4.oor;
    if (e4.oor) begin
      e5_next.year   = '0;
      e5_next.month  = '0;
      e5_next.day    = '0;
      e5_next.hour   = '0;
      e5_next.minute = '0;
      e5_next.second = '0;
      e5_next.milli  = '0;
      e5_next.wd     = '0;
    end else begin
      e5_next.year   = e4.yr[mcd_pkg::YEAR_W-1:0];
      e5_next.month  = mi + 4'd1;
      e5_next.day    = dd[4:0];
      e5_next.hour   = e4.hour;
      e5_next.minute = e4.minute;
      e5_next.second = e4.second;
      e5_next.milli  = e4.milli;
      e5_next.wd     = e4.wd;
    end
  end

  always_ff @(posedge clk) begin
    if (en[mcd_pkg::DIV_STAGES+1]) begin
      e1 <= e1_next;
    end
    if (en[mcd_pkg::DIV_STAGES+2]) begin
      e2 <= e2_next;
    end
    if (en[mcd_pkg::DIV_STAGES+3]) begin
      e3 <= e3_next;
    end
    if (en[mcd_pkg::DIV_STAGES+4]) begin
      e4 <= e4_next;
    end
    if (en[mcd_pkg::DIV_STAGES+5]) begin
      e5 <= e5_next;
    end
  end

  assign out_valid    = v[mcd_pkg::PIPE_STAGES-1];
  assign year_num     = e5.year;
  assign month_num    = e5.month;
  assign day_num      = e5.day;
  assign hour_num     = e5.hour;
  assign minute_num   = e5.minute;
  assign second_num   = e5.second;
  assign milli_num    = e5.milli;
  assign weekday      = e5.wd;
  assign out_of_range = e5.oor;

endmodule

/* rtl/core/mcd_checker.sv */
// Port-level checks of the civil date unit, bound to the top level
`include "millisecond_count_to_civil_date_unit_assert.svh"

module mcd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mcd_pkg::YEAR_W-1:0] year_num,
  input logic [3:0]                 month_num,
  input logic [4:0]                 day_num,
  input logic [4:0]                 hour_num,
  input logic [5:0]                 minute_num,
  input logic [5:0]                 second_num,
  input logic [9:0]                 milli_num,
  input logic [2:0]                 weekday,
  input logic                       out_of_range
);

  // an out-of-range word carries nothing but the flag
  `MCD_ASSERT_IMP(a_oor_zero, clk, rst, out_valid && out_of_range, (year_num == '0) && (month_num == '0) && (day_num == '0) && (hour_num == '0) && (minute_num == '0) && (second_num == '0) && (milli_num == '0) && (weekday == '0))

  `MCD_ASSERT_IMP(a_date_range, clk, rst, out_valid && !out_of_range, (month_num != 4'd0) && (month_num <= 4'd12) && (day_num != 5'd0))

  `MCD_ASSERT_IMP(a_time_range, clk, rst, out_valid, (hour_num < 5'd24) && (minute_num < 6'd60) && (second_num < 6'd60) && (milli_num < 10'd1000) && (weekday < 3'd7))

  `MCD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(year_num) && $stable(milli_num) && $stable(out_of_range))

  `MCD_ASSERT_ALWAYS_NXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind millisecond_count_to_civil_date_unit mcd_checker u_mcd_checker (.*);

/* dv/civil_date_check.sv */
// Channel monitor, calendar predictor and result comparison for the civil date unit
module civil_date_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [mcd_pkg::MS_W-1:0]   ms_count,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [mcd_pkg::YEAR_W-1:0] year_num,
  input  logic [3:0]                 month_num,
  input  logic [4:0]                 day_num,
  input  logic [4:0]                 hour_num,
  input  logic [5:0]                 minute_num,
  input  logic [5:0]                 second_num,
  input  logic [9:0]                 milli_num,
  input  logic [2:0]                 weekday,
  input  logic                       out_of_range,
  output int                         dates_owed,
  output int                         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LAST_YEAR  = mcd_pkg::MAX_YEAR_DEF;
  localparam longint unsigned DAY_LEN    = 86400000;
  localparam longint unsigned CYCLE_LEN  = 365 * 303 + 366 * 97;
  localparam longint unsigned LAST_MS    =
    (LAST_YEAR * 365 + LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400) * DAY_LEN;
  localparam int unsigned     FEBRUARY   = 2;
  localparam int unsigned     MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic                       oor;
    logic [mcd_pkg::YEAR_W-1:0] year;
    logic [3:0]                 month;
    logic [4:0]                 day;
    logic [4:0]                 hour;
    logic [5:0]                 minute;
    logic [5:0]                 second;
    logic [9:0]                 milli;
    logic [2:0]                 wd;
  } civil_t;

  civil_t due_dates [$];
  int     bad = 0;

  function automatic bit is_leap(longint unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic civil_t civil_from_ms(logic [mcd_pkg::MS_W-1:0] ms);
    civil_t          r;
    longint unsigned total;
    longint unsigned days;
    longint unsigned tod;
    longint unsigned left;
    longint unsigned yr;
    longint unsigned span;
    int unsigned     mon;
    int unsigned     mlen;
    r = '0;
    total = 64'(ms);
    if (total >= LAST_MS) begin
      r.oor = 1'b1;
      return r;
    end
    days = total / DAY_LEN;
    tod  = total % DAY_LEN;
    yr   = (days / CYCLE_LEN) * 400 + 1;
    left = days % CYCLE_LEN;
    span = is_leap(yr) ? 366 : 365;
    while (left >= span) begin
      left -= span;
      yr++;
      span = is_leap(yr) ? 366 : 365;
    end
    mon = 1;
    mlen = MONTH_DAYS[0];
    while (mon < 12 && left >= mlen) begin
      left -= mlen;
      mon++;
      mlen = MONTH_DAYS[mon-1] + ((mon == FEBRUARY && is_leap(yr)) ? 1 : 0);
    end
    r.year   = yr[mcd_pkg::YEAR_W-1:0];
    r.month  = mon[3:0];
    r.day    = 5'(left + 1);
    r.hour   = 5'(tod / 3600000);
    r.minute = 6'((tod / 60000) % 60);
    r.second = 6'((tod / 1000) % 60);
    r.milli  = 10'(tod % 1000);
    r.wd     = 3'(days % 7);
    return r;
  endfunction

  task automatic check_field(string tag, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, tag, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    civil_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_dates.size() == 0) begin
          $display("%0t: result word with nothing expected, got year %0d month %0d day %0d",
                   $time, year_num, month_num, day_num);
          bad++;
        end else begin
          want = due_dates.pop_front();
          check_field("year_num", want.year, year_num);
          check_field("month_num", want.month, month_num);
          check_field("day_num", want.day, day_num);
          check_field("hour_num", want.hour, hour_num);
          check_field("minute_num", want.minute, minute_num);
          check_field("second_num", want.second, second_num);
          check_field("milli_num", want.milli, milli_num);
          check_field("weekday", want.wd, weekday);
          check_field("out_of_range", want.oor, out_of_range);
        end
      end
      if (in_valid && in_ready) due_dates.push_back(civil_from_ms(ms_count));
    end
    dates_owed <= due_dates.size();
    mismatch_count <= bad;
  end

endmodule

/* dv/tb_millisecond_count_to_civil_date_unit.sv */
// Stimulus, clock, reset and verdict for the civil date unit
module tb_millisecond_count_to_civil_date_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LAST_YEAR = mcd_pkg::MAX_YEAR_DEF;
  localparam longint unsigned DAY_LEN   = 86400000;
  localparam longint unsigned LAST_MS   =
    (LAST_YEAR * 365 + LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400) * DAY_LEN;
  localparam longint unsigned TOP_MS    = (64'd1 << mcd_pkg::MS_W) - 1;
  localparam int              RANDOM_WORDS = 1650;
  localparam int              CALM_WORDS   = 150;
  localparam int              EDGE_WORDS   = 21;

  // Calendar corners: day, year, century and 400-year wraps, leap and non-leap February,
  // the last in-range millisecond and the first past it, and bit patterns
  localparam longint unsigned EDGE_COUNTS [EDGE_WORDS] = '{
    0, 1, DAY_LEN - 1, DAY_LEN,
    DAY_LEN * 1460 + DAY_LEN - 1, DAY_LEN * 1461,
    DAY_LEN * 36523 + 12345678, DAY_LEN * 36524,
    DAY_LEN * 146096 + DAY_LEN - 1, DAY_LEN * 146097,
    DAY_LEN * 693653 + DAY_LEN - 1, DAY_LEN * 693654,
    DAY_LEN * 730178 + 45296789, DAY_LEN * 730179,
    DAY_LEN * 730484 + DAY_LEN - 1,
    LAST_MS - 1, LAST_MS, TOP_MS,
    64'h0000_5555_5555_5555, 64'h0001_AAAA_AAAA_AAAA, 64'h0000_0F0F_0F0F_0F0F
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [mcd_pkg::MS_W-1:0]   ms_count = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [mcd_pkg::YEAR_W-1:0] year_num;
  logic [3:0]                 month_num;
  logic [4:0]                 day_num;
  logic [4:0]                 hour_num;
  logic [5:0]                 minute_num;
  logic [5:0]                 second_num;
  logic [9:0]                 milli_num;
  logic [2:0]                 weekday;
  logic                       out_of_range;
  int                         dates_owed;
  int                         mismatch_count;
  bit                         calm = 1'b0;

  always #5 clk = ~clk;

  millisecond_count_to_civil_date_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ms_count(ms_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .year_num(year_num), .month_num(month_num), .day_num(day_num),
    .hour_num(hour_num), .minute_num(minute_num), .second_num(second_num),
    .milli_num(milli_num), .weekday(weekday), .out_of_range(out_of_range)
  );

  civil_date_check checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ms_count(ms_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .year_num(year_num), .month_num(month_num), .day_num(day_num),
    .hour_num(hour_num), .minute_num(minute_num), .second_num(second_num),
    .milli_num(milli_num), .weekday(weekday), .out_of_range(out_of_range),
    .dates_owed(dates_owed), .mismatch_count(mismatch_count)
  );

  function automatic longint unsigned rand_wide();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return 64'(w[mcd_pkg::MS_W-1:0]);
  endfunction

  function automatic longint unsigned pick_count();
    longint unsigned days;
    case ($urandom_range(0, 9))
      0: return rand_wide();
      1: return LAST_MS + rand_wide() % (TOP_MS - LAST_MS + 1);
      2: return LAST_MS - 3000 + $urandom_range(0, 6000);
      3, 4: begin
        // land right at the start or end of a day
        days = rand_wide() % (LAST_MS / DAY_LEN);
        return days * DAY_LEN + ($urandom_range(0, 1) ? DAY_LEN - 1 : 0);
      end
      default: return rand_wide() % LAST_MS;
    endcase
  endfunction

  task automatic send_count(longint unsigned v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ms_count <= v[mcd_pkg::MS_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Output side: random stall bursts, none once the run calms down
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    #3000000;
    $display("tb_millisecond_count_to_civil_date_unit failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < EDGE_WORDS; i++) send_count(EDGE_COUNTS[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      send_count(pick_count());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_owed != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_millisecond_count_to_civil_date_unit passed");
    end else begin
      $display("tb_millisecond_count_to_civil_date_unit failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mcd_pkg.sv
rtl/core/mcd_day_div.sv
rtl/core/millisecond_count_to_civil_date_unit.sv
rtl/core/mcd_checker.sv
dv/civil_date_check.sv
dv/tb_millisecond_count_to_civil_date_unit.sv
